// ----- design/stm_pkg.sv -----
package stm_pkg;

    localparam int ROW_W          = 8;
    localparam int COL_W          = 8;
    localparam int VAL_W          = 32;
    localparam int ENTRY_W        = ROW_W + COL_W + VAL_W;
    localparam int TDATA_W        = 48;
    localparam int S_TUSER_W      = 2;
    localparam int M_TUSER_W      = 2;
    localparam int LIST_DEPTH_DEF = 32;

    localparam logic [S_TUSER_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [S_TUSER_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [S_TUSER_W-1:0] KIND_RUN    = 2'd2;

    localparam int FLAG_SAT   = 0;
    localparam int FLAG_EMPTY = 1;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic clear_idx;
        logic step;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic both_empty;
        logic out_free;
        logic last_step;
    } stat_t;

endpackage

// ----- design/sparse_triplet_merge_add.sv -----
// Sparse matrix addition over two coordinate lists (row, col, value).
// Input words: s_axis_tuser selects the kind: load into list A, load into
// list B, or run the merge; code 3 is dropped. Loads carry the triplet in
// s_axis_tdata and are taken one per cycle; a load into a full list is
// dropped. Loads produce no output word.
// A run walks both lists in (row, col) order and emits one triplet per cycle
// on the m_axis side; equal coordinates give one word with the sum,
// clipped to 32 bits signed and flagged in tuser. m_axis_tlast marks the
// final word; both lists are empty afterwards. A run on two empty lists
// gives one word with the empty flag and tlast set, all fields zero.
// The list memories have a registered read and the output word is
// registered; after the first result word, one word per cycle follows.
// s_axis_tready is low while a run drains.
// A stalled receiver holds the current word and freezes the merge; loads
// are still taken while the final word of the previous run waits.
// Reset clears both list counts, the controller and the output valid.
module sparse_triplet_merge_add #(
    parameter int LIST_DEPTH = stm_pkg::LIST_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [stm_pkg::TDATA_W-1:0]     s_axis_tdata,  // row, col, value
    input  logic [stm_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [stm_pkg::TDATA_W-1:0]     m_axis_tdata,  // out_row, out_col, out_value
    output logic [stm_pkg::M_TUSER_W-1:0]   m_axis_tuser,  // saturated, empty_res
    output logic                            m_axis_tlast
);

    stm_pkg::cmd_t  cmd;
    stm_pkg::stat_t stat;

    logic [stm_pkg::ROW_W-1:0]        out_row;
    logic [stm_pkg::COL_W-1:0]        out_col;
    logic signed [stm_pkg::VAL_W-1:0] out_value;
    logic                             out_sat, out_empty;

    stm_ctrl u_ctrl (
        .clk     (aclk),
        .rst_n   (aresetn),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    stm_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .clk       (aclk),
        .rst_n     (aresetn),
        .cmd       (cmd),
        .in_entry  (s_axis_tdata[stm_pkg::ENTRY_W-1:0]),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_sat   (out_sat),
        .out_empty (out_empty),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_col, out_row};
    assign m_axis_tuser = {out_empty, out_sat};

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step || cmd.emit_empty |=> m_axis_tvalid)
        else $error("merge step did not register an output word");

    a_run_clears_lists: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && stat.last_step |=> stat.both_empty)
        else $error("lists not emptied after final merge word");

    a_empty_word_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[stm_pkg::FLAG_EMPTY]
            |-> m_axis_tlast && !m_axis_tuser[stm_pkg::FLAG_SAT] && (m_axis_tdata == '0))
        else $error("empty result word carries data or lacks tlast");

    a_no_load_during_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step || cmd.emit_empty |-> !cmd.load_a && !cmd.load_b)
        else $error("load taken while a merge is draining");

endmodule

// ----- design/stm_ram.sv -----
module stm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/stm_ctrl.sv -----
module stm_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_valid,
    input  logic [stm_pkg::S_TUSER_W-1:0]        s_kind,
    output logic                                 s_ready,
    input  stm_pkg::stat_t                       stat,
    output stm_pkg::cmd_t                        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        cmd            = '0;
        cmd.load_a     = s_fire && (s_kind == stm_pkg::KIND_LOAD_A);
        cmd.load_b     = s_fire && (s_kind == stm_pkg::KIND_LOAD_B);
        cmd.clear_idx  = (state_reg == ST_IDLE);
        cmd.step       = (state_reg == ST_MERGE) && stat.out_free;
        cmd.emit_empty = (state_reg == ST_EMPTY) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_kind == stm_pkg::KIND_RUN)) begin
                    state_next = stat.both_empty ? ST_EMPTY : ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (cmd.step && stat.last_step) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (cmd.emit_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/stm_dp.sv -----
module stm_dp #(
    parameter int LIST_DEPTH = stm_pkg::LIST_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  stm_pkg::cmd_t                   cmd,
    input  logic [stm_pkg::ENTRY_W-1:0]     in_entry,
    output stm_pkg::stat_t                  stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [stm_pkg::ROW_W-1:0]       out_row,
    output logic [stm_pkg::COL_W-1:0]       out_col,
    output logic signed [stm_pkg::VAL_W-1:0] out_value,
    output logic                            out_sat,
    output logic                            out_empty,
    output logic                            out_last
);

    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int KW  = stm_pkg::ROW_W + stm_pkg::COL_W;
    localparam int VW  = stm_pkg::VAL_W;
    localparam int VLO = KW;

    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] i_reg, i_next, i_adv;
    logic [CW-1:0] j_reg, j_next, j_adv;

    logic [stm_pkg::ENTRY_W-1:0] rd_a, rd_b;
    logic [KW-1:0]               key_a, key_b;
    logic                        a_more, b_more, take_a, take_b, take_both;
    logic                        last_step;
    logic signed [VW:0]          sum;
    logic signed [VW-1:0]        sum_sat;
    logic                        sum_clip;

    logic                        out_valid_reg;
    logic [stm_pkg::ROW_W-1:0]   out_row_reg;
    logic [stm_pkg::COL_W-1:0]   out_col_reg;
    logic signed [VW-1:0]        out_value_reg;
    logic                        out_sat_reg, out_empty_reg, out_last_reg;
    logic                        out_free;

    stm_ram #(.WIDTH(stm_pkg::ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (cmd.load_a && (count_a_reg < FULL_CNT)),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (in_entry),
        .raddr (i_next[AW-1:0]),
        .rdata (rd_a)
    );

    stm_ram #(.WIDTH(stm_pkg::ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (cmd.load_b && (count_b_reg < FULL_CNT)),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (in_entry),
        .raddr (j_next[AW-1:0]),
        .rdata (rd_b)
    );

    // key is row-major: row above col
    assign key_a = {rd_a[stm_pkg::ROW_W-1:0], rd_a[KW-1:stm_pkg::ROW_W]};
    assign key_b = {rd_b[stm_pkg::ROW_W-1:0], rd_b[KW-1:stm_pkg::ROW_W]};

    assign a_more    = i_reg < count_a_reg;
    assign b_more    = j_reg < count_b_reg;
    assign take_a    = a_more && (!b_more || (key_a < key_b));
    assign take_b    = b_more && (!a_more || (key_b < key_a));
    assign take_both = !take_a && !take_b;

    assign i_adv     = i_reg + CW'(take_a || take_both);
    assign j_adv     = j_reg + CW'(take_b || take_both);
    assign last_step = (i_adv >= count_a_reg) && (j_adv >= count_b_reg);

    assign i_next = cmd.clear_idx ? '0 : (cmd.step ? i_adv : i_reg);
    assign j_next = cmd.clear_idx ? '0 : (cmd.step ? j_adv : j_reg);

    assign sum      = {rd_a[stm_pkg::ENTRY_W-1], rd_a[stm_pkg::ENTRY_W-1:VLO]}
                    + {rd_b[stm_pkg::ENTRY_W-1], rd_b[stm_pkg::ENTRY_W-1:VLO]};
    assign sum_clip = sum[VW] != sum[VW-1];
    assign sum_sat  = sum_clip ? (sum[VW] ? VAL_MIN : VAL_MAX) : sum[VW-1:0];

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (cmd.step && last_step) begin
            count_a_next = '0;
            count_b_next = '0;
        end else begin
            if (cmd.load_a && (count_a_reg < FULL_CNT)) begin
                count_a_next = count_a_reg + CW'(1);
            end
            if (cmd.load_b && (count_b_reg < FULL_CNT)) begin
                count_b_next = count_b_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            if (cmd.step || cmd.emit_empty) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.step) begin
            out_empty_reg <= 1'b0;
            out_last_reg  <= last_step;
            if (take_a) begin
                out_row_reg   <= rd_a[stm_pkg::ROW_W-1:0];
                out_col_reg   <= rd_a[KW-1:stm_pkg::ROW_W];
                out_value_reg <= rd_a[stm_pkg::ENTRY_W-1:VLO];
                out_sat_reg   <= 1'b0;
            end else if (take_b) begin
                out_row_reg   <= rd_b[stm_pkg::ROW_W-1:0];
                out_col_reg   <= rd_b[KW-1:stm_pkg::ROW_W];
                out_value_reg <= rd_b[stm_pkg::ENTRY_W-1:VLO];
                out_sat_reg   <= 1'b0;
            end else begin
                out_row_reg   <= rd_a[stm_pkg::ROW_W-1:0];
                out_col_reg   <= rd_a[KW-1:stm_pkg::ROW_W];
                out_value_reg <= sum_sat;
                out_sat_reg   <= sum_clip;
            end
        end else if (cmd.emit_empty) begin
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    always_comb begin
        stat            = '0;
        stat.both_empty = (count_a_reg == '0) && (count_b_reg == '0);
        stat.out_free   = out_free;
        stat.last_step  = last_step;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;
    assign out_empty = out_empty_reg;
    assign out_last  = out_last_reg;

endmodule
